// File: design/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Holds payload structs, configuration layout, status codes and phase codes.
// No dependencies.
package uer_pkg;

  localparam int DIST_W     = 10;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH_US = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LOW_US    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_US_PER_CM        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CM           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CM           = 3'd5;

  // Register reset values
  localparam logic [15:0]       RST_TIMEOUT_US       = 16'd30000;
  localparam logic [7:0]        RST_TRIGGER_WIDTH_US = 8'd10;
  localparam logic [7:0]        RST_SETTLE_LOW_US    = 8'd2;
  localparam logic [7:0]        RST_US_PER_CM        = 8'd58;
  localparam logic [DIST_W-1:0] RST_MIN_CM           = 10'd2;
  localparam logic [DIST_W-1:0] RST_MAX_CM           = 10'd400;

  // Measurement status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ECHO   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SETTLE = 5'b00010,
    PH_TRIG   = 5'b00100,
    PH_WAIT   = 5'b01000,
    PH_MEAS   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [15:0]       timeout_us;
    logic [7:0]        trigger_width_us;
    logic [7:0]        settle_low_us;
    logic [7:0]        us_per_cm;
    logic [DIST_W-1:0] min_cm;
    logic [DIST_W-1:0] max_cm;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic                trigger_level;
    logic                busy_res;
    logic                done_res;
    logic [DIST_W-1:0]   distance_cm;
    logic [STATUS_W-1:0] status;
  } out_t;

endpackage

// File: design/uer_cfg.sv
// Configuration register file for the ultrasonic echo ranger.
// Depends on uer_pkg for the register layout, indexes and reset values.
module uer_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
  output uer_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_us       <= uer_pkg::RST_TIMEOUT_US;
      cfg.trigger_width_us <= uer_pkg::RST_TRIGGER_WIDTH_US;
      cfg.settle_low_us    <= uer_pkg::RST_SETTLE_LOW_US;
      cfg.us_per_cm        <= uer_pkg::RST_US_PER_CM;
      cfg.min_cm           <= uer_pkg::RST_MIN_CM;
      cfg.max_cm           <= uer_pkg::RST_MAX_CM;
    end else if (cfg_valid) begin
      case (cfg_index)
        uer_pkg::REG_TIMEOUT_US:       cfg.timeout_us       <= cfg_data[15:0];
        uer_pkg::REG_TRIGGER_WIDTH_US: cfg.trigger_width_us <= cfg_data[7:0];
        uer_pkg::REG_SETTLE_LOW_US:    cfg.settle_low_us    <= cfg_data[7:0];
        uer_pkg::REG_US_PER_CM:        cfg.us_per_cm        <= cfg_data[7:0];
        uer_pkg::REG_MIN_CM:           cfg.min_cm           <= cfg_data[uer_pkg::DIST_W-1:0];
        uer_pkg::REG_MAX_CM:           cfg.max_cm           <= cfg_data[uer_pkg::DIST_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule

// File: design/uer_seq.sv
// Ranging sequencer: phase, tick counter, running quotient and last result.
// Depends on uer_pkg for payload, configuration and phase types.
module uer_seq #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  uer_pkg::in_t  item,
  input  uer_pkg::cfg_t cfg,
  output uer_pkg::out_t res
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int QUO_W = uer_pkg::DIST_W + 1;

  uer_pkg::phase_t phase, phase_next;
  logic [COUNT_WIDTH-1:0]       tick_count, tick_count_next, tick_inc;
  logic [QUO_W-1:0]             quo, quo_next;
  logic [7:0]                   rem, rem_next;
  logic [uer_pkg::DIST_W-1:0]   last_distance, last_distance_next;
  logic [uer_pkg::STATUS_W-1:0] last_status, last_status_next;

  logic       done;
  logic [7:0] trig_w;
  logic [7:0] div;
  logic       cnt_timeout;
  logic       inc_timeout;
  logic       rem_wrap;

  assign trig_w = (cfg.trigger_width_us == 8'd0) ? 8'd1 : cfg.trigger_width_us;
  assign div    = (cfg.us_per_cm == 8'd0) ? 8'd1 : cfg.us_per_cm;

  // Saturating tick increment and the two timeout checks
  assign tick_inc    = (&tick_count) ? tick_count : tick_count + COUNT_WIDTH'(1);
  assign cnt_timeout = (CMP_W'(tick_count) > CMP_W'(cfg.timeout_us)) || (&tick_count);
  assign inc_timeout = (CMP_W'(tick_inc) > CMP_W'(cfg.timeout_us)) || (&tick_inc);

  // Remainder reaches the divisor: roll into the quotient
  assign rem_wrap = (({1'b0, rem} + 9'd1) == {1'b0, div});

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    quo_next           = quo;
    rem_next           = rem;
    last_distance_next = last_distance;
    last_status_next   = last_status;
    done               = 1'b0;
    case (phase)
      uer_pkg::PH_SETTLE: begin
        if (tick_count >= COUNT_WIDTH'(cfg.settle_low_us)) begin
          phase_next      = uer_pkg::PH_TRIG;
          tick_count_next = COUNT_WIDTH'(1);
        end else begin
          tick_count_next = tick_inc;
        end
      end
      uer_pkg::PH_TRIG: begin
        if (tick_count >= COUNT_WIDTH'(trig_w)) begin
          phase_next      = uer_pkg::PH_WAIT;
          tick_count_next = COUNT_WIDTH'(1);
        end else begin
          tick_count_next = tick_inc;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (item.echo_level) begin
          phase_next      = uer_pkg::PH_MEAS;
          tick_count_next = COUNT_WIDTH'(1);
          if (div == 8'd1) begin
            quo_next = QUO_W'(1);
            rem_next = 8'd0;
          end else begin
            quo_next = '0;
            rem_next = 8'd1;
          end
        end else if (cnt_timeout) begin
          phase_next         = uer_pkg::PH_IDLE;
          tick_count_next    = '0;
          last_status_next   = uer_pkg::ST_NO_ECHO;
          last_distance_next = '0;
          done               = 1'b1;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      uer_pkg::PH_MEAS: begin
        if (item.echo_level) begin
          tick_count_next = tick_inc;
          // hold quotient/remainder once the count saturates (timeout follows)
          if (!(&tick_count)) begin
            if (rem_wrap) begin
              rem_next = 8'd0;
              quo_next = (&quo) ? quo : quo + QUO_W'(1);
            end else begin
              rem_next = rem + 8'd1;
            end
          end
          if (inc_timeout) begin
            phase_next         = uer_pkg::PH_IDLE;
            tick_count_next    = '0;
            last_status_next   = uer_pkg::ST_TOO_LONG;
            last_distance_next = '0;
            done               = 1'b1;
          end
        end else begin
          phase_next      = uer_pkg::PH_IDLE;
          tick_count_next = '0;
          done            = 1'b1;
          if ((quo < {1'b0, cfg.min_cm}) || (quo > {1'b0, cfg.max_cm})) begin
            last_status_next   = uer_pkg::ST_OUT_RANGE;
            last_distance_next = '0;
          end else begin
            last_status_next   = uer_pkg::ST_OK;
            last_distance_next = quo[uer_pkg::DIST_W-1:0];
          end
        end
      end
      default: begin
        phase_next      = uer_pkg::PH_IDLE;
        tick_count_next = '0;
        if (item.start_req) begin
          phase_next      = (cfg.settle_low_us == 8'd0) ? uer_pkg::PH_TRIG
                                                        : uer_pkg::PH_SETTLE;
          tick_count_next = COUNT_WIDTH'(1);
        end
      end
    endcase
  end

  always_comb begin
    res.trigger_level = (phase_next == uer_pkg::PH_TRIG);
    res.busy_res      = (phase_next != uer_pkg::PH_IDLE);
    res.done_res      = done;
    res.distance_cm   = last_distance_next;
    res.status        = last_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= uer_pkg::PH_IDLE;
      tick_count    <= '0;
      last_distance <= '0;
      last_status   <= uer_pkg::ST_OK;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      last_distance <= last_distance_next;
      last_status   <= last_status_next;
    end
  end

  // quotient tracking is set on entry to the measure phase
  always_ff @(posedge clk) begin
    if (step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

// File: design/ultrasonic_echo_ranger_unit.sv
// Top level of the ultrasonic echo ranger: input register, sequencer, result register.
// Depends on uer_pkg, uer_cfg and uer_seq.
//
// Each transfer on the input channel is one microsecond tick carrying a start
// request and the sampled echo level; each tick yields exactly one result
// transfer with trigger level, busy, done, distance and status. The block
// takes one tick per clock cycle while the output is not stalled. A tick
// passes through an input register and then one pass of sequencer logic into
// the result register. The distance comes from a quotient and remainder that
// advance with each high echo tick, so the divide by us_per_cm costs nothing
// at echo fall. The input side stalls only when a tick is waiting in the input
// register and the result register is full and stalled. Configuration writes
// are always ready and take effect at once; write them only while no
// measurement is running.
module ultrasonic_echo_ranger_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  uer_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output uer_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);

  uer_pkg::cfg_t cfg;
  uer_pkg::in_t  item;
  uer_pkg::out_t res;
  logic          item_valid;
  logic          out_free;
  logic          step;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Result register can load when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  // Advance the held tick through the sequencer into the result register
  assign step     = item_valid && out_free;
  // Hold off new ticks only while the held tick cannot advance
  assign in_stall = item_valid && !out_free;

  uer_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  // Input register: capture each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  // Result register: load on a sequencer step, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

  // A finishing tick leaves the block idle
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.busy_res)
    else $error("done result shows busy");

  // Trigger is only driven during a measurement
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.trigger_level) |-> out_data.busy_res)
    else $error("trigger high while not busy");

  // Error results always carry a zero distance
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != uer_pkg::ST_OK)) |-> (out_data.distance_cm == '0))
    else $error("nonzero distance with error status");

  // A tick stalled at the input register is still held next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_stall |=> item_valid)
    else $error("held tick lost while stalled");

endmodule
